/* rtl/core/radial_lens_point_mapper_macros.svh */
// assertion macros for the radial lens point mapper
// used by the top level; expects clk_i and rst_ni in scope
`ifndef RADIAL_LENS_POINT_MAPPER_MACROS_SVH
`define RADIAL_LENS_POINT_MAPPER_MACROS_SVH

// checked only while out of reset
`define RLPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define RLPM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/core/rlpm_pkg.sv */
// shared constants, register codes and clamp helper for the lens mapper
// no dependencies
`default_nettype none

package rlpm_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int CFG_WIDTH       = 32;
  localparam logic [CFG_WIDTH-1:0] SCALE_RESET = 32'h0100_0000;

  typedef enum logic [1:0] {
    CFG_CENTER_X   = 2'd0,
    CFG_CENTER_Y   = 2'd1,
    CFG_DIST_COEFF = 2'd2,
    CFG_SCALE_GAIN = 2'd3
  } cfg_idx_e;

  localparam logic [127:0] CAP62 = 128'd1 << 62;

  function automatic logic [62:0] clamp62(input logic [127:0] v);
    if (v > CAP62) return CAP62[62:0];
    return v[62:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/rlpm_mul.sv */
// shift-add multiplier: a row of cells, one multiplier bit per cell
// uses rlpm_pkg for parameter defaults
`default_nettype none

module rlpm_mul #(
  parameter int NA    = rlpm_pkg::COORD_WIDTH_DEF,
  parameter int NB    = rlpm_pkg::COORD_WIDTH_DEF,
  parameter int LANES = 1,
  parameter int SW    = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [LANES-1:0][NA-1:0]      a_i,
  input  logic [LANES-1:0][NB-1:0]      b_i,
  input  logic [SW-1:0]                 side_i,
  output logic                          valid_o,
  output logic [LANES-1:0][NA+NB-1:0]   p_o,
  output logic [SW-1:0]                 side_o
);

  localparam int PW = NA + NB;

  logic [NB:0]                vld;
  logic [SW-1:0]              sd  [NB+1];
  logic [LANES-1:0][NA-1:0]   av  [NB+1];
  logic [LANES-1:0][NB-1:0]   bv  [NB+1];
  logic [LANES-1:0][PW-1:0]   acc [NB+1];

  assign vld[0] = valid_i;
  assign sd[0]  = side_i;
  assign av[0]  = a_i;
  assign bv[0]  = b_i;
  assign acc[0] = '0;

  for (genvar c = 0; c < NB; c++) begin : g_cell
    logic                       vld_q;
    logic [SW-1:0]              sd_q;
    logic [LANES-1:0][NA-1:0]   a_q;
    logic [LANES-1:0][NB-1:0]   b_q;
    logic [LANES-1:0][PW-1:0]   acc_q;
    logic [LANES-1:0][PW-1:0]   acc_d;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      assign acc_d[l] = bv[c][l][c] ? acc[c][l] + (PW'(av[c][l]) << c) : acc[c][l];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld[c];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sd_q  <= sd[c];
        a_q   <= av[c];
        b_q   <= bv[c];
        acc_q <= acc_d;
      end
    end

    assign vld[c+1] = vld_q;
    assign sd[c+1]  = sd_q;
    assign av[c+1]  = a_q;
    assign bv[c+1]  = b_q;
    assign acc[c+1] = acc_q;
  end

  assign valid_o = vld[NB];
  assign side_o  = sd[NB];
  assign p_o     = acc[NB];

endmodule

`default_nettype wire

/* rtl/core/rlpm_div.sv */
// restoring divider: a row of cells, one quotient bit per cell
// lanes share one divisor; uses rlpm_pkg for parameter defaults
`default_nettype none

module rlpm_div #(
  parameter int NN    = rlpm_pkg::COORD_WIDTH_DEF,
  parameter int ND    = rlpm_pkg::CFG_WIDTH,
  parameter int LANES = 1,
  parameter int SW    = 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [LANES-1:0][NN-1:0]  n_i,
  input  logic [ND-1:0]             d_i,
  input  logic [SW-1:0]             side_i,
  output logic                      valid_o,
  output logic [LANES-1:0][NN-1:0]  q_o,
  output logic [SW-1:0]             side_o
);

  logic [NN:0]                vld;
  logic [SW-1:0]              sd  [NN+1];
  logic [ND-1:0]              dv  [NN+1];
  logic [LANES-1:0][ND-1:0]   rem [NN+1];
  logic [LANES-1:0][NN-1:0]   nq  [NN+1];

  assign vld[0] = valid_i;
  assign sd[0]  = side_i;
  assign dv[0]  = d_i;
  assign rem[0] = '0;
  assign nq[0]  = n_i;

  for (genvar c = 0; c < NN; c++) begin : g_cell
    logic                       vld_q;
    logic [SW-1:0]              sd_q;
    logic [ND-1:0]              d_q;
    logic [LANES-1:0][ND-1:0]   rem_q;
    logic [LANES-1:0][NN-1:0]   nq_q;
    logic [LANES-1:0][ND-1:0]   rem_d;
    logic [LANES-1:0][NN-1:0]   nq_d;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [ND:0] trial;
      logic        take;
      assign trial    = {rem[c][l], nq[c][l][NN-1]};
      assign take     = trial >= {1'b0, dv[c]};
      assign rem_d[l] = take ? ND'(trial - {1'b0, dv[c]}) : trial[ND-1:0];
      assign nq_d[l]  = {nq[c][l][NN-2:0], take};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld[c];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sd_q  <= sd[c];
        d_q   <= dv[c];
        rem_q <= rem_d;
        nq_q  <= nq_d;
      end
    end

    assign vld[c+1] = vld_q;
    assign sd[c+1]  = sd_q;
    assign dv[c+1]  = d_q;
    assign rem[c+1] = rem_q;
    assign nq[c+1]  = nq_q;
  end

  assign valid_o = vld[NN];
  assign side_o  = sd[NN];
  assign q_o     = nq[NN];

endmodule

`default_nettype wire

/* rtl/core/rlpm_sqrt.sv */
// integer square root: a row of cells, one root bit per cell
// uses rlpm_pkg for parameter defaults
`default_nettype none

module rlpm_sqrt #(
  parameter int NX = 2 * rlpm_pkg::COORD_WIDTH_DEF,
  parameter int SW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NX-1:0]     x_i,
  input  logic [SW-1:0]     side_i,
  output logic              valid_o,
  output logic [NX/2-1:0]   root_o,
  output logic [SW-1:0]     side_o
);

  localparam int H  = NX / 2;
  localparam int RW = H + 1;

  logic [H:0]     vld;
  logic [SW-1:0]  sd   [H+1];
  logic [NX-1:0]  xs   [H+1];
  logic [RW-1:0]  rem  [H+1];
  logic [H-1:0]   root [H+1];

  assign vld[0]  = valid_i;
  assign sd[0]   = side_i;
  assign xs[0]   = x_i;
  assign rem[0]  = '0;
  assign root[0] = '0;

  for (genvar c = 0; c < H; c++) begin : g_cell
    logic           vld_q;
    logic [SW-1:0]  sd_q;
    logic [NX-1:0]  xs_q;
    logic [RW-1:0]  rem_q;
    logic [H-1:0]   root_q;
    logic [RW+1:0]  cur;
    logic [RW+1:0]  trial;
    logic           take;

    assign cur   = {rem[c], xs[c][NX-1 -: 2]};
    assign trial = (RW + 2)'({root[c], 2'b01});
    assign take  = cur >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld[c];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sd_q   <= sd[c];
        xs_q   <= {xs[c][NX-3:0], 2'b00};
        rem_q  <= take ? RW'(cur - trial) : RW'(cur);
        root_q <= {root[c][H-2:0], take};
      end
    end

    assign vld[c+1]  = vld_q;
    assign sd[c+1]   = sd_q;
    assign xs[c+1]   = xs_q;
    assign rem[c+1]  = rem_q;
    assign root[c+1] = root_q;
  end

  assign valid_o = vld[H];
  assign side_o  = sd[H];
  assign root_o  = root[H];

endmodule

`default_nettype wire

/* rtl/core/radial_lens_point_mapper.sv */
// Radial lens point mapper: maps one Q16.16 point per word through a first-order
// radial lens model, forward (tuser 0) or inverse (tuser 1). One word is taken
// every cycle; the pipeline stalls as a whole only while a finished result waits
// and m_axis_tready_i is low. Each word passes in order through the chained bit-per-cell
// units: the two-lane normalizing divider, square, radius root, the three multiplies of
// the forward factor and offset, delta root, length divider, rescale multiply and
// rescale divider, plus the output register.
// Configuration writes are taken at once and must only come while the block is idle.
`default_nettype none

`include "radial_lens_point_mapper_macros.svh"

module radial_lens_point_mapper #(
  parameter int   COORD_WIDTH = rlpm_pkg::COORD_WIDTH_DEF,
  localparam int  TDW = ((2 * COORD_WIDTH + 7) / 8) * 8,
  localparam int  CDW = (COORD_WIDTH > rlpm_pkg::CFG_WIDTH) ? COORD_WIDTH : rlpm_pkg::CFG_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [CDW-1:0]   cfg_data_i,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [TDW-1:0]   s_axis_tdata_i,   // in_x, in_y
  input  logic             s_axis_tuser_i,   // kind
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [TDW-1:0]   m_axis_tdata_o,   // out_x, out_y
  output logic             m_axis_tuser_o    // valid_res
);

  localparam int W   = COORD_WIDTH;
  localparam int NW1 = W + 25;
  localparam int TW  = W + 32;
  localparam int AW  = W + 33;
  localparam int FW  = W + 25;
  localparam int DLW = W + 35;
  localparam int NX2 = 2 * ((W + 48) / 2);
  localparam int SQ  = NX2 / 2;
  localparam int NW8 = SQ + 16;
  localparam int PW9 = W + 63;

  localparam logic [NW1-1:0]  HALF_N  = NW1'(1) << (W - 1);
  localparam logic [TW-1:0]   ONE43_T = TW'(1) << 43;
  localparam logic [W+33:0]   ONE44_T = (W + 34)'(1) << 44;
  localparam logic [AW-1:0]   ONE44_A = AW'(1) << 44;
  localparam logic [DLW-1:0]  ONE44_D = DLW'(1) << 44;
  localparam logic [SQ-1:0]   ONE28_S = SQ'(1) << 28;
  localparam logic signed [63:0] MAXV = (64'sd1 <<< (W - 1)) - 64'sd1;
  localparam logic signed [63:0] MINV = -MAXV - 64'sd1;

  typedef struct packed {
    logic         kind;
    logic [W-1:0] x;
    logic [W-1:0] y;
    logic         sdx;
    logic         sdy;
  } in_t;

  typedef struct packed {
    logic           kind;
    logic [W-1:0]   mvx;
    logic [W-1:0]   mvy;
    logic           svx;
    logic           svy;
    logic [W-1:0]   r;
    logic           bad_f;
    logic           bad_i;
    logic [AW-1:0]  a;
    logic [DLW-1:0] dl;
    logic [W-1:0]   fox;
    logic [W-1:0]   foy;
  } ctx_t;

  localparam int CW = $bits(ctx_t);

  function automatic logic [W-1:0] norm_clamp(input logic [NW1-1:0] q, input logic neg);
    logic [NW1-1:0] cap;
    cap = neg ? HALF_N : HALF_N - 1'b1;
    return (q > cap) ? cap[W-1:0] : q[W-1:0];
  endfunction

  function automatic logic [W-1:0] sat_w(input logic signed [63:0] v);
    if (v > MAXV) return MAXV[W-1:0];
    if (v < MINV) return MINV[W-1:0];
    return v[W-1:0];
  endfunction

  function automatic logic signed [63:0] sgn64(input logic [62:0] m, input logic neg);
    logic signed [63:0] v;
    v = $signed({1'b0, m});
    return neg ? -v : v;
  endfunction

  // configuration registers
  logic [W-1:0]  cx_q, cy_q;
  logic [31:0]   k_q, s_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cy_q <= '0;
      k_q  <= '0;
      s_q  <= rlpm_pkg::SCALE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (rlpm_pkg::cfg_idx_e'(cfg_index_i))
        rlpm_pkg::CFG_CENTER_X:   cx_q <= cfg_data_i[W-1:0];
        rlpm_pkg::CFG_CENTER_Y:   cy_q <= cfg_data_i[W-1:0];
        rlpm_pkg::CFG_DIST_COEFF: k_q  <= cfg_data_i[31:0];
        rlpm_pkg::CFG_SCALE_GAIN: s_q  <= cfg_data_i[31:0];
      endcase
    end
  end

  logic        s_zero, k_zero, kneg;
  logic [31:0] mk;
  logic signed [63:0] cxe, cye;

  assign s_zero = (s_q == '0);
  assign k_zero = (k_q == '0);
  assign kneg   = k_q[31];
  assign mk     = kneg ? -k_q : k_q;
  assign cxe    = $signed({{(64 - W){cx_q[W-1]}}, cx_q});
  assign cye    = $signed({{(64 - W){cy_q[W-1]}}, cy_q});

  // output register and global advance
  logic         m_valid_q, res_valid_q;
  logic [W-1:0] out_x_q, out_y_q;
  logic         en;

  assign en              = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // input: offsets from the center for the inverse normalization
  logic [W-1:0]        x_in, y_in;
  logic signed [W:0]   dvx, dvy;
  logic [W:0]          dmx, dmy;
  in_t                 side0;
  logic [1:0][NW1-1:0] num0;

  assign x_in  = s_axis_tdata_i[W-1:0];
  assign y_in  = s_axis_tdata_i[2*W-1:W];
  assign dvx   = $signed({x_in[W-1], x_in}) - $signed({cx_q[W-1], cx_q});
  assign dvy   = $signed({y_in[W-1], y_in}) - $signed({cy_q[W-1], cy_q});
  assign dmx   = dvx[W] ? (W + 1)'(-dvx) : (W + 1)'(dvx);
  assign dmy   = dvy[W] ? (W + 1)'(-dvy) : (W + 1)'(dvy);
  assign num0  = {{dmy, 24'd0}, {dmx, 24'd0}};
  assign side0 = '{kind: s_axis_tuser_i, x: x_in, y: y_in, sdx: dvx[W], sdy: dvy[W]};

  logic                v1;
  logic [1:0][NW1-1:0] q1;
  in_t                 side1;

  rlpm_div #(.NN(NW1), .ND(32), .LANES(2), .SW($bits(in_t))) u_div_norm (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(s_axis_tvalid_i && s_axis_tready_o),
    .n_i(num0), .d_i(s_q), .side_i(side0),
    .valid_o(v1), .q_o(q1), .side_o(side1)
  );

  // pick the vector whose radius is taken
  logic [W-1:0] nmx, nmy, axv, ayv;
  ctx_t         c1;

  assign nmx = norm_clamp(q1[0], side1.sdx);
  assign nmy = norm_clamp(q1[1], side1.sdy);
  assign axv = side1.x[W-1] ? -side1.x : side1.x;
  assign ayv = side1.y[W-1] ? -side1.y : side1.y;

  always_comb begin
    c1      = '0;
    c1.kind = side1.kind;
    c1.mvx  = side1.kind ? nmx : axv;
    c1.mvy  = side1.kind ? nmy : ayv;
    c1.svx  = side1.kind ? (side1.sdx && nmx != '0) : side1.x[W-1];
    c1.svy  = side1.kind ? (side1.sdy && nmy != '0) : side1.y[W-1];
  end

  logic              v2;
  logic [1:0][2*W-1:0] p2;
  logic [CW-1:0]     s2;
  ctx_t              c2;

  rlpm_mul #(.NA(W), .NB(W), .LANES(2), .SW(CW)) u_mul_sq (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1),
    .a_i({c1.mvy, c1.mvx}), .b_i({c1.mvy, c1.mvx}), .side_i(c1),
    .valid_o(v2), .p_o(p2), .side_o(s2)
  );
  assign c2 = ctx_t'(s2);

  logic          v3;
  logic [W-1:0]  r3;
  logic [CW-1:0] s3;
  ctx_t          c3;

  rlpm_sqrt #(.NX(2 * W), .SW(CW)) u_sqrt_rad (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v2),
    .x_i(p2[0] + p2[1]), .side_i(c2),
    .valid_o(v3), .root_o(r3), .side_o(s3)
  );

  always_comb begin
    c3   = ctx_t'(s3);
    c3.r = r3;
  end

  logic          v4;
  logic [TW-1:0] p4;
  logic [CW-1:0] s4;
  ctx_t          c4;
  logic [W+33:0] t4x;

  rlpm_mul #(.NA(W), .NB(32), .LANES(1), .SW(CW)) u_mul_kr (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v3),
    .a_i(c3.r), .b_i(mk), .side_i(c3),
    .valid_o(v4), .p_o(p4), .side_o(s4)
  );

  assign t4x = {p4, 2'b00};

  always_comb begin
    c4       = ctx_t'(s4);
    c4.bad_f = kneg && (p4 > ONE43_T);
    c4.bad_i = kneg && (t4x > ONE44_T);
    c4.a     = kneg ? ONE44_A - AW'(p4) : ONE44_A + AW'(p4);
    c4.dl    = kneg ? ONE44_D - DLW'(t4x) : ONE44_D + DLW'(t4x);
  end

  logic             v5;
  logic [AW+31:0]   p5;
  logic [CW-1:0]    s5;
  ctx_t             c5;
  logic [FW-1:0]    f5;

  rlpm_mul #(.NA(AW), .NB(32), .LANES(1), .SW(CW)) u_mul_gain (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v4),
    .a_i(c4.a), .b_i(s_q), .side_i(c4),
    .valid_o(v5), .p_o(p5), .side_o(s5)
  );
  assign c5 = ctx_t'(s5);
  assign f5 = p5[AW+31:40];

  logic                  v6;
  logic [1:0][FW+W-1:0]  p6;
  logic [CW-1:0]         s6;
  ctx_t                  c6;

  rlpm_mul #(.NA(FW), .NB(W), .LANES(2), .SW(CW)) u_mul_fwd (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v5),
    .a_i({f5, f5}), .b_i({c5.mvy, c5.mvx}), .side_i(c5),
    .valid_o(v6), .p_o(p6), .side_o(s6)
  );

  always_comb begin
    c6     = ctx_t'(s6);
    c6.fox = sat_w(cxe + sgn64(rlpm_pkg::clamp62(128'(p6[0][2*W+24:28])), c6.svx));
    c6.foy = sat_w(cye + sgn64(rlpm_pkg::clamp62(128'(p6[1][2*W+24:28])), c6.svy));
  end

  logic          v7;
  logic [SQ-1:0] sq7, m7;
  logic [CW-1:0] s7;
  ctx_t          c7;

  rlpm_sqrt #(.NX(NX2), .SW(CW)) u_sqrt_delta (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v6),
    .x_i(NX2'({c6.dl, 12'd0})), .side_i(c6),
    .valid_o(v7), .root_o(sq7), .side_o(s7)
  );
  assign c7 = ctx_t'(s7);
  assign m7 = kneg ? ONE28_S - sq7 : sq7 - ONE28_S;

  logic           v8;
  logic [NW8-1:0] q8;
  logic [CW-1:0]  s8;
  ctx_t           c8;
  logic [62:0]    len8;

  rlpm_div #(.NN(NW8), .ND(33), .LANES(1), .SW(CW)) u_div_len (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v7),
    .n_i({m7, 16'd0}), .d_i({mk, 1'b0}), .side_i(c7),
    .valid_o(v8), .q_o(q8), .side_o(s8)
  );
  assign c8   = ctx_t'(s8);
  assign len8 = rlpm_pkg::clamp62(128'(q8));

  logic                v9;
  logic [1:0][PW9-1:0] p9;
  logic [CW-1:0]       s9;
  ctx_t                c9;

  rlpm_mul #(.NA(63), .NB(W), .LANES(2), .SW(CW)) u_mul_len (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v8),
    .a_i({len8, len8}), .b_i({c8.mvy, c8.mvx}), .side_i(c8),
    .valid_o(v9), .p_o(p9), .side_o(s9)
  );
  assign c9 = ctx_t'(s9);

  logic                v10;
  logic [1:0][PW9-1:0] q10;
  logic [CW-1:0]       s10;
  ctx_t                c10;

  rlpm_div #(.NN(PW9), .ND(W), .LANES(2), .SW(CW)) u_div_rad (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v9),
    .n_i(p9), .d_i(c9.r), .side_i(c9),
    .valid_o(v10), .q_o(q10), .side_o(s10)
  );
  assign c10 = ctx_t'(s10);

  // result selection
  logic         res_valid;
  logic [W-1:0] res_x, res_y;

  always_comb begin
    res_valid = 1'b1;
    res_x     = '0;
    res_y     = '0;
    if (!c10.kind) begin
      if (s_zero || !c10.bad_f) begin
        res_x = c10.fox;
        res_y = c10.foy;
      end else begin
        res_valid = 1'b0;
      end
    end else if (s_zero) begin
      res_valid = 1'b0;
    end else if (k_zero) begin
      res_x = c10.svx ? -c10.mvx : c10.mvx;
      res_y = c10.svy ? -c10.mvy : c10.mvy;
    end else if (c10.bad_i) begin
      res_valid = 1'b0;
    end else if (c10.r != '0) begin
      res_x = sat_w(sgn64(rlpm_pkg::clamp62(128'(q10[0])), c10.svx));
      res_y = sat_w(sgn64(rlpm_pkg::clamp62(128'(q10[1])), c10.svy));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= v10;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_valid_q <= res_valid;
      out_x_q     <= res_x;
      out_y_q     <= res_y;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = TDW'({out_y_q, out_x_q});
  assign m_axis_tuser_o  = res_valid_q;

  `RLPM_ASSERT(a_invalid_zero, m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o == '0, "invalid word carries nonzero coordinates")
  `RLPM_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !m_axis_tvalid_o, "output valid during reset")
  `RLPM_ASSERT(a_inv_zero_gain, v10 && c10.kind && s_zero |-> !res_valid, "inverse with zero gain marked valid")
  `RLPM_ASSERT(a_fwd_zero_gain, v10 && !c10.kind && s_zero |-> res_valid && res_x == cx_q, "forward with zero gain is not the center")
  `RLPM_ASSERT(a_out_source, $rose(m_valid_q) |-> $past(v10), "output word without a finished pipeline word")

endmodule

`default_nettype wire
